// ----- hdl/qfpr_pkg.sv -----
`timescale 1ns / 1ps

package qfpr_pkg;

  localparam int NUM_USERS_DEF      = 4;
  localparam int NUM_FRAMES_DEF     = 16;
  localparam int PAGES_PER_USER_DEF = 64;

  localparam int USER_W   = 2;
  localparam int PAGE_W   = 6;
  localparam int FRAME_W  = 4;
  localparam int COUNT_W  = 32;
  localparam int QUOTA_W  = 5;
  localparam int PACKED_W = 20;
  localparam int ACTIVE_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUOTA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUOTA     = 2'd2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET    = 5'd16;
  localparam logic [PACKED_W-1:0] MIN_QUOTA_RESET = 20'd0;
  localparam logic [PACKED_W-1:0] MAX_QUOTA_RESET = 20'd541200;

  localparam logic [COUNT_W-1:0] SAT32 = '1;

  // Map port commands: set marks a key resident, clr drops the evicted key.
  typedef struct packed {
    logic set;
    logic clr;
  } map_cmd_t;

  // Five-bit quota slot of user u; slots past the register read as zero.
  function automatic logic [QUOTA_W-1:0] quota_of(input logic [PACKED_W-1:0] qp,
                                                   input int unsigned u);
    logic [PACKED_W-1:0] sh;
    sh = '0;
    if (u * QUOTA_W >= PACKED_W) begin
      return '0;
    end
    sh = qp >> (u * QUOTA_W);
    return sh[QUOTA_W-1:0];
  endfunction

endpackage

// ----- hdl/qfpr_ifs.sv -----
`timescale 1ns / 1ps

interface qfpr_in_if;
  logic                         valid;
  logic                         ready;
  logic [qfpr_pkg::USER_W-1:0]  user;
  logic [qfpr_pkg::PAGE_W-1:0]  page;
  modport source (output valid, user, page, input ready);
  modport sink (input valid, user, page, output ready);
endinterface

interface qfpr_out_if;
  logic                          valid;
  logic                          ready;
  logic [qfpr_pkg::FRAME_W-1:0]  frame;
  logic                          hit;
  logic                          error;
  logic [qfpr_pkg::COUNT_W-1:0]  fault_count;
  modport source (output valid, frame, hit, error, fault_count, input ready);
  modport sink (input valid, frame, hit, error, fault_count, output ready);
endinterface

interface qfpr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [qfpr_pkg::CFG_IDX_W-1:0] index;
  logic [qfpr_pkg::PACKED_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/quota_fifo_page_replacement_unit.sv -----
`timescale 1ns / 1ps
// A hit or a bad request goes from accept through lookup to the output register; a miss served
// from a never-used frame also passes commit, and a miss that evicts adds a full frame scan.
// One transaction at a time; the frame scan looks at one frame per cycle through a
// single 32-bit load-time comparator, so the scan dominates an eviction.
// Reset (rst, synchronous): all frames invalid, page table empty, counters zero, and the
// configuration registers back to 16 active frames, zero minimum and 16 maximum quota.
module quota_fifo_page_replacement_unit #(
  parameter int NUM_USERS      = qfpr_pkg::NUM_USERS_DEF,
  parameter int NUM_FRAMES     = qfpr_pkg::NUM_FRAMES_DEF,
  parameter int PAGES_PER_USER = qfpr_pkg::PAGES_PER_USER_DEF
) (
  input logic             clk,
  input logic             rst,
  qfpr_cfg_if.sink        cfg,
  qfpr_in_if.sink         req,
  qfpr_out_if.source      rsp
);

  localparam int MAP_DEPTH = NUM_USERS * PAGES_PER_USER;
  localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int PW = (PAGES_PER_USER > 1) ? $clog2(PAGES_PER_USER) : 1;
  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int KW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int NW = $clog2(NUM_FRAMES + 1);
  localparam int CW = $clog2(NUM_FRAMES + 1);

  // The sequencer walks one transaction through lookup, an optional frame scan and pick,
  // the commit of the new mapping on a miss and the hand-off to the output register.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_PICK,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [qfpr_pkg::ACTIVE_W-1:0] active_frames;
  logic [qfpr_pkg::PACKED_W-1:0] min_quota;
  logic [qfpr_pkg::PACKED_W-1:0] max_quota;

  // Frame table. Owner, page and load time are only read for valid frames.
  logic [NUM_FRAMES-1:0] frame_valid;
  logic [UW-1:0]         frame_owner [NUM_FRAMES];
  logic [PW-1:0]         frame_page  [NUM_FRAMES];
  logic [31:0]           frame_time  [NUM_FRAMES];

  logic [CW-1:0] user_count [NUM_USERS];
  logic [CW-1:0] user_count_next [NUM_USERS];
  logic [NW-1:0] next_free;
  logic [31:0]   access_time;
  logic [31:0]   misses;

  // Current transaction.
  logic          cur_bad;
  logic [UW-1:0] cur_u;
  logic [PW-1:0] cur_pg;
  logic [KW-1:0] cur_key;

  // Scan state: eligibility of each user, best candidate so far.
  logic [NUM_USERS-1:0] elig;
  logic [FW-1:0]        idx;
  logic                 found;
  logic [31:0]          best_t;
  logic [UW-1:0]        best_o;
  logic [PW-1:0]        best_pg;
  logic [FW-1:0]        best_f;
  logic                 evict;
  logic [FW-1:0]        victim;

  // Finished result waiting for the output register.
  logic                          res_hit;
  logic                          res_err;
  logic [qfpr_pkg::FRAME_W-1:0]  res_frame;

  logic                          out_valid;
  logic [qfpr_pkg::FRAME_W-1:0]  out_frame;
  logic                          out_hit;
  logic                          out_err;
  logic [31:0]                   out_faults;

  // Page table port.
  logic [KW-1:0]      in_key;
  logic               map_resident;
  logic [FW-1:0]      map_frame;
  qfpr_pkg::map_cmd_t map_cmd;
  logic [KW-1:0]      old_key;

  // Lookup-time decisions.
  logic [qfpr_pkg::QUOTA_W-1:0] umax;
  logic [31:0]                  limit;
  logic                         at_max;
  logic                         take_free;
  logic [NUM_USERS-1:0]         elig_next;
  logic                         better;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.frame       = out_frame;
  assign rsp.hit         = out_hit;
  assign rsp.error       = out_err;
  assign rsp.fault_count = out_faults;

  assign in_key = KW'(32'(req.user) * 32'(PAGES_PER_USER) + 32'(req.page));
  assign old_key = KW'(32'(best_o) * 32'(PAGES_PER_USER) + 32'(best_pg));

  assign map_cmd.set = (state == S_COMMIT);
  assign map_cmd.clr = (state == S_COMMIT) && evict;

  qfpr_page_map #(
    .DEPTH (MAP_DEPTH),
    .KW    (KW),
    .FW    (FW)
  ) u_map (
    .clk         (clk),
    .rst         (rst),
    .rd_addr     (in_key),
    .rd_resident (map_resident),
    .rd_frame    (map_frame),
    .cmd         (map_cmd),
    .set_addr    (cur_key),
    .set_frame   (victim),
    .clr_addr    (old_key)
  );

  // Quota checks for the requesting user. At its maximum quota a user may only
  // recycle its own frames; otherwise it may also take from users that hold
  // more than their minimum.
  always_comb begin
    umax      = qfpr_pkg::quota_of(max_quota, 32'(cur_u));
    limit     = (32'(active_frames) < 32'(NUM_FRAMES)) ? 32'(active_frames)
                                                        : 32'(NUM_FRAMES);
    at_max    = 32'(user_count[cur_u]) >= 32'(umax);
    take_free = !at_max && (32'(next_free) < limit);
    for (int v = 0; v < NUM_USERS; v++) begin
      if (32'(v) == 32'(cur_u)) begin
        elig_next[v] = 1'b1;
      end else begin
        elig_next[v] = !at_max &&
          (32'(user_count[v]) > 32'(qfpr_pkg::quota_of(min_quota, 32'(v))));
      end
    end
  end

  // Oldest load time wins; equal times go to the lower user, and the scan order
  // already favors the lower frame.
  always_comb begin
    better = frame_valid[idx] && elig[frame_owner[idx]] &&
             (!found || (frame_time[idx] < best_t) ||
              ((frame_time[idx] == best_t) && (frame_owner[idx] < best_o)));
  end

  always_comb begin
    for (int v = 0; v < NUM_USERS; v++) begin
      user_count_next[v] = user_count[v];
      if (evict && (32'(best_o) == 32'(v)) && (user_count[v] != '0)) begin
        user_count_next[v] = user_count_next[v] - CW'(1);
      end
      if (32'(cur_u) == 32'(v)) begin
        user_count_next[v] = user_count_next[v] + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active_frames <= qfpr_pkg::ACTIVE_RESET;
      min_quota     <= qfpr_pkg::MIN_QUOTA_RESET;
      max_quota     <= qfpr_pkg::MAX_QUOTA_RESET;
      frame_valid   <= '0;
      for (int v = 0; v < NUM_USERS; v++) begin
        user_count[v] <= '0;
      end
      next_free     <= '0;
      access_time   <= '0;
      misses        <= '0;
      out_valid     <= 1'b0;
      found         <= 1'b0;
      evict         <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          qfpr_pkg::CFG_ACTIVE_FRAMES: active_frames <= cfg.data[qfpr_pkg::ACTIVE_W-1:0];
          qfpr_pkg::CFG_MIN_QUOTA:     min_quota     <= cfg.data;
          qfpr_pkg::CFG_MAX_QUOTA:     max_quota     <= cfg.data;
          default: ;
        endcase
      end

      // A result that leaves while the next one is loaded is replaced below.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_bad <= (32'(req.user) >= 32'(NUM_USERS)) ||
                       (32'(req.page) >= 32'(PAGES_PER_USER));
            cur_u   <= UW'(req.user);
            cur_pg  <= PW'(req.page);
            cur_key <= in_key;
            state   <= S_LOOK;
          end
        end

        S_LOOK: begin
          res_hit   <= 1'b0;
          res_err   <= 1'b0;
          res_frame <= '0;
          if (cur_bad) begin
            res_err <= 1'b1;
            state   <= S_DONE;
          end else if (map_resident) begin
            res_hit   <= 1'b1;
            res_frame <= qfpr_pkg::FRAME_W'(map_frame);
            if (access_time != qfpr_pkg::SAT32) begin
              access_time <= access_time + 32'd1;
            end
            state <= S_DONE;
          end else if (take_free) begin
            victim    <= FW'(next_free);
            evict     <= 1'b0;
            next_free <= next_free + NW'(1);
            state     <= S_COMMIT;
          end else begin
            elig  <= elig_next;
            idx   <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (better) begin
            found   <= 1'b1;
            best_t  <= frame_time[idx];
            best_o  <= frame_owner[idx];
            best_pg <= frame_page[idx];
            best_f  <= idx;
          end
          if (32'(idx) == 32'(NUM_FRAMES - 1)) begin
            state <= S_PICK;
          end else begin
            idx <= idx + FW'(1);
          end
        end

        S_PICK: begin
          if (found) begin
            victim <= best_f;
            evict  <= 1'b1;
            state  <= S_COMMIT;
          end else begin
            res_err <= 1'b1;
            state   <= S_DONE;
          end
        end

        S_COMMIT: begin
          frame_valid[victim] <= 1'b1;
          frame_owner[victim] <= cur_u;
          frame_page[victim]  <= cur_pg;
          frame_time[victim]  <= access_time;
          for (int v = 0; v < NUM_USERS; v++) begin
            user_count[v] <= user_count_next[v];
          end
          if (misses != qfpr_pkg::SAT32) begin
            misses <= misses + 32'd1;
          end
          if (access_time != qfpr_pkg::SAT32) begin
            access_time <= access_time + 32'd1;
          end
          res_frame <= qfpr_pkg::FRAME_W'(victim);
          evict     <= 1'b0;
          state     <= S_DONE;
        end

        S_DONE: begin
          // The output register takes the result once the previous one is gone.
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_frame  <= res_frame;
            out_hit    <= res_hit;
            out_err    <= res_err;
            out_faults <= misses;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/qfpr_page_map.sv -----
`timescale 1ns / 1ps

// Page-to-frame table with per-entry resident bits and a registered read.
module qfpr_page_map #(
  parameter int DEPTH = qfpr_pkg::NUM_USERS_DEF * qfpr_pkg::PAGES_PER_USER_DEF,
  parameter int KW    = 8,
  parameter int FW    = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [KW-1:0]      rd_addr,
  output logic               rd_resident,
  output logic [FW-1:0]      rd_frame,
  input  qfpr_pkg::map_cmd_t cmd,
  input  logic [KW-1:0]      set_addr,
  input  logic [FW-1:0]      set_frame,
  input  logic [KW-1:0]      clr_addr
);

  logic [FW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] resident;

  always_ff @(posedge clk) begin
    if (cmd.set) begin
      mem[set_addr] <= set_frame;
    end
    rd_frame <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resident    <= '0;
      rd_resident <= 1'b0;
    end else begin
      if (cmd.clr) begin
        resident[clr_addr] <= 1'b0;
      end
      if (cmd.set) begin
        resident[set_addr] <= 1'b1;
      end
      rd_resident <= resident[rd_addr];
    end
  end

endmodule
